// ===== design/bcdclk_pkg.sv =====
// bcdclk_pkg: shared types, codes and decode tables for the bcd clock
// used by bcdclk_core, bcdclk_disp and bcd_clock_with_keypad_set_top
`default_nettype none

package bcdclk_pkg;

    localparam logic [1:0] MODE_SECOND = 2'd0;
    localparam logic [1:0] MODE_SCAN   = 2'd1;
    localparam logic [1:0] MODE_KEY    = 2'd2;

    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_SET        = 4'd11;

    localparam int unsigned NUM_DIGITS = 6;
    localparam logic [2:0]  ENTRY_FULL = 3'd6;
    localparam logic [2:0]  DASH_SLOT  = 3'd6;

    localparam logic [6:0] SEG_DASH  = 7'b1000000;
    localparam logic [6:0] SEG_BLANK = 7'b0000000;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        t_digits    digits;
        logic       set_mode;
        logic [2:0] entry_count;
        logic [2:0] scan_pos;
    } t_clk_state;

    function automatic logic [6:0] seg_decode(input logic [3:0] value);
        logic [6:0] seg;
        unique case (value)
            4'd0:    seg = 7'b0111111;
            4'd1:    seg = 7'b0000110;
            4'd2:    seg = 7'b1011011;
            4'd3:    seg = 7'b1001111;
            4'd4:    seg = 7'b1100110;
            4'd5:    seg = 7'b1101101;
            4'd6:    seg = 7'b1111101;
            4'd7:    seg = 7'b0000111;
            4'd8:    seg = 7'b1111111;
            4'd9:    seg = 7'b1101111;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // scan position to digit slot, dash slot for the separators
    function automatic logic [2:0] pos_to_slot(input logic [2:0] pos);
        logic [2:0] slot;
        unique case (pos)
            3'd0:    slot = 3'd0;
            3'd1:    slot = 3'd1;
            3'd2:    slot = DASH_SLOT;
            3'd3:    slot = 3'd2;
            3'd4:    slot = 3'd3;
            3'd5:    slot = DASH_SLOT;
            3'd6:    slot = 3'd4;
            default: slot = 3'd5;
        endcase
        return slot;
    endfunction

endpackage

`default_nettype wire

// ===== design/bcdclk_core.sv =====
// bcdclk_core: time, set-mode and scan state with its next-state logic
// depends on bcdclk_pkg
`default_nettype none

module bcdclk_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_advance,
    input  wire [1:0]               i_mode,
    input  wire [3:0]               i_key,
    output bcdclk_pkg::t_clk_state  o_next,
    output logic                    o_rejected
);
    import bcdclk_pkg::*;

    t_clk_state r_state;
    t_clk_state n_state;
    t_digits    ticked;
    t_digits    shifted;
    logic [2:0] count_inc;
    logic       hours_ok;
    logic       entry_ok;
    logic       rejected;

    // one-second carry chain
    always_comb begin
        ticked    = r_state.digits;
        ticked[5] = r_state.digits[5] + 4'd1;
        if (ticked[5] >= 4'd10) begin
            ticked[5] = 4'd0;
            ticked[4] = r_state.digits[4] + 4'd1;
            if (ticked[4] >= 4'd6) begin
                ticked[4] = 4'd0;
                ticked[3] = r_state.digits[3] + 4'd1;
                if (ticked[3] >= 4'd10) begin
                    ticked[3] = 4'd0;
                    ticked[2] = r_state.digits[2] + 4'd1;
                    if (ticked[2] >= 4'd6) begin
                        ticked[2] = 4'd0;
                        ticked[1] = r_state.digits[1] + 4'd1;
                        if (r_state.digits[0] >= 4'd2 && ticked[1] >= 4'd4) begin
                            ticked[0] = 4'd0;
                            ticked[1] = 4'd0;
                        end else if (ticked[1] >= 4'd10) begin
                            ticked[1] = 4'd0;
                            ticked[0] = r_state.digits[0] + 4'd1;
                        end
                    end
                end
            end
        end
    end

    // key entry shifts in from the right
    assign shifted   = {i_key, r_state.digits[5], r_state.digits[4],
                        r_state.digits[3], r_state.digits[2], r_state.digits[1]};
    assign count_inc = r_state.entry_count + 3'd1;
    assign hours_ok  = (shifted[0] == 4'd2 && shifted[1] < 4'd4) ||
                       (shifted[0] < 4'd2 && shifted[1] < 4'd10);
    assign entry_ok  = hours_ok && shifted[2] < 4'd6 && shifted[3] < 4'd10 &&
                       shifted[4] < 4'd6 && shifted[5] < 4'd10;

    always_comb begin
        n_state  = r_state;
        rejected = 1'b0;
        unique case (i_mode)
            MODE_SECOND: begin
                if (!r_state.set_mode) begin
                    n_state.digits = ticked;
                end
            end
            MODE_SCAN: begin
                n_state.scan_pos = r_state.scan_pos + 3'd1;
            end
            MODE_KEY: begin
                if (i_key == KEY_SET) begin
                    if (!r_state.set_mode) begin
                        n_state.set_mode    = 1'b1;
                        n_state.entry_count = 3'd0;
                        n_state.digits      = '0;
                    end
                end else if (i_key <= KEY_LAST_DIGIT && r_state.set_mode) begin
                    n_state.digits      = shifted;
                    n_state.entry_count = count_inc;
                    if (count_inc >= ENTRY_FULL) begin
                        n_state.entry_count = 3'd0;
                        if (entry_ok) begin
                            n_state.set_mode = 1'b0;
                        end else begin
                            n_state.digits = '0;
                            rejected       = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    assign o_next     = n_state;
    assign o_rejected = rejected;

endmodule

`default_nettype wire

// ===== design/bcdclk_disp.sv =====
// bcdclk_disp: seven-segment and digit-select decode of one clock state
// depends on bcdclk_pkg
`default_nettype none

module bcdclk_disp (
    input  bcdclk_pkg::t_clk_state i_state,
    output logic [6:0]             o_segments,
    output logic [7:0]             o_digit_select,
    output logic                   o_setting,
    output logic [2:0]             o_digits_entered
);
    import bcdclk_pkg::*;

    logic [2:0] slot;
    logic [3:0] slot_sum;

    assign slot     = pos_to_slot(i_state.scan_pos);
    assign slot_sum = {1'b0, slot} + {1'b0, i_state.entry_count};

    always_comb begin
        priority if (slot == DASH_SLOT) begin
            o_segments = SEG_DASH;
        end else if (i_state.set_mode && slot_sum < 4'(NUM_DIGITS)) begin
            o_segments = SEG_BLANK;
        end else begin
            o_segments = seg_decode(i_state.digits[slot]);
        end
    end

    assign o_digit_select   = ~(8'd1 << i_state.scan_pos);
    assign o_setting        = i_state.set_mode;
    assign o_digits_entered = i_state.set_mode ? i_state.entry_count : 3'd0;

endmodule

`default_nettype wire

// ===== design/bcd_clock_with_keypad_set_top.sv =====
// bcd_clock_with_keypad_set_top: input register, clock core, display decode
// and result register; depends on bcdclk_pkg, bcdclk_core and bcdclk_disp
//
// A 24-hour BCD clock with keypad time entry and an eight-position
// multiplexed seven-segment display. Every accepted word (second tick, scan
// tick or key press) gives exactly one result word describing the state
// after it. The block takes one word per cycle unless the result side stalls;
// a word goes from the input register to the result register; a stalled
// result holds the input register, so the input stalls only while both are full.
`default_nettype none

module bcd_clock_with_keypad_set_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire [1:0]  i_mode,
    input  wire [3:0]  i_key,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [6:0] o_segments,
    output logic [7:0] o_digit_select,
    output logic       o_setting,
    output logic [2:0] o_digits_entered,
    output logic       o_entry_rejected
);
    import bcdclk_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_mode;
    logic [3:0] r_key;
    logic       r_out_valid;
    logic [6:0] r_segments;
    logic [7:0] r_digit_select;
    logic       r_setting;
    logic [2:0] r_digits_entered;
    logic       r_entry_rejected;

    logic       out_load;
    logic       advance;
    t_clk_state next_state;
    logic       rejected;
    logic [6:0] n_segments;
    logic [7:0] n_digit_select;
    logic       n_setting;
    logic [2:0] n_digits_entered;

    assign out_load = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_load;
    assign o_stall  = r_in_valid && !out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_mode <= i_mode;
            r_key  <= i_key;
        end
    end

    bcdclk_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_mode     (r_mode),
        .i_key      (r_key),
        .o_next     (next_state),
        .o_rejected (rejected)
    );

    bcdclk_disp u_disp (
        .i_state          (next_state),
        .o_segments       (n_segments),
        .o_digit_select   (n_digit_select),
        .o_setting        (n_setting),
        .o_digits_entered (n_digits_entered)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_segments       <= n_segments;
            r_digit_select   <= n_digit_select;
            r_setting        <= n_setting;
            r_digits_entered <= n_digits_entered;
            r_entry_rejected <= rejected;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_segments       = r_segments;
    assign o_digit_select   = r_digit_select;
    assign o_setting        = r_setting;
    assign o_digits_entered = r_digits_entered;
    assign o_entry_rejected = r_entry_rejected;

    a_one_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones(o_digit_select) == 7)
        else $error("digit select not a single active position");

    a_count_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_setting || o_digits_entered == 3'd0) && o_digits_entered <= 3'd5)
        else $error("entry count out of range or outside set mode");

    a_reject_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_entry_rejected) |-> (o_setting && o_digits_entered == 3'd0))
        else $error("rejected entry did not stay in set mode with cleared count");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_mode) && $stable(r_key))
        else $error("input register changed while the result side was stalled");

endmodule

`default_nettype wire

// ===== sim/bcd_clock_with_keypad_set_top_test.sv =====
// bcd_clock_with_keypad_set_top_test: self-checking bench for the bcd clock top
// predicts every result word from its own clock model and compares field by field
// depends on bcdclk_pkg and bcd_clock_with_keypad_set_top

import bcdclk_pkg::*;

typedef struct packed {
    logic [6:0] segments;
    logic [7:0] digit_select;
    logic       setting;
    logic [2:0] digits_entered;
    logic       entry_rejected;
} display_word_t;

class clock_scoreboard;
    localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };
    localparam logic [2:0] SLOT_OF_POS [8] = '{
        3'd0, 3'd1, DASH_SLOT, 3'd2, 3'd3, DASH_SLOT, 3'd4, 3'd5
    };

    logic [3:0] digits [NUM_DIGITS];
    logic       set_mode;
    logic [2:0] entry_count;
    logic [2:0] scan_pos;

    display_word_t expected_words [$];
    int errors;
    int words;
    int active_words;
    int checked;
    int times_set;
    int entries_refused;
    int midnight_wraps;

    function void clear_digits();
        for (int k = 0; k < NUM_DIGITS; k++) digits[k] = 4'd0;
    endfunction

    function void reset_state();
        clear_digits();
        set_mode    = 1'b0;
        entry_count = 3'd0;
        scan_pos    = 3'd0;
    endfunction

    function void advance_second();
        digits[5] = digits[5] + 4'd1;
        if (digits[5] < 10) return;
        digits[5] = 4'd0;
        digits[4] = digits[4] + 4'd1;
        if (digits[4] < 6) return;
        digits[4] = 4'd0;
        digits[3] = digits[3] + 4'd1;
        if (digits[3] < 10) return;
        digits[3] = 4'd0;
        digits[2] = digits[2] + 4'd1;
        if (digits[2] < 6) return;
        digits[2] = 4'd0;
        digits[1] = digits[1] + 4'd1;
        if (digits[0] >= 2 && digits[1] >= 4) begin
            digits[0] = 4'd0;
            digits[1] = 4'd0;
            midnight_wraps++;
        end else if (digits[1] >= 10) begin
            digits[1] = 4'd0;
            digits[0] = digits[0] + 4'd1;
        end
    endfunction

    function bit time_is_legal();
        bit hours_ok;
        hours_ok = (digits[0] == 2 && digits[1] < 4) || (digits[0] < 2 && digits[1] < 10);
        return hours_ok && digits[2] < 6 && digits[3] < 10 && digits[4] < 6 && digits[5] < 10;
    endfunction

    function void note_input(logic [1:0] mode, logic [3:0] key);
        display_word_t w;
        logic [2:0]    slot;
        logic          refused;
        refused = 1'b0;
        words++;
        case (mode)
            MODE_SECOND: begin
                if (!set_mode) begin
                    advance_second();
                    active_words++;
                end
            end
            MODE_SCAN: begin
                scan_pos = scan_pos + 3'd1;
                active_words++;
            end
            MODE_KEY: begin
                if (key == KEY_SET) begin
                    if (!set_mode) begin
                        set_mode    = 1'b1;
                        entry_count = 3'd0;
                        clear_digits();
                        active_words++;
                    end
                end else if (key <= KEY_LAST_DIGIT && set_mode) begin
                    for (int k = 0; k < NUM_DIGITS - 1; k++) digits[k] = digits[k + 1];
                    digits[NUM_DIGITS - 1] = key;
                    entry_count = entry_count + 3'd1;
                    active_words++;
                    if (entry_count >= ENTRY_FULL) begin
                        entry_count = 3'd0;
                        if (time_is_legal()) begin
                            set_mode = 1'b0;
                            times_set++;
                        end else begin
                            clear_digits();
                            refused = 1'b1;
                            entries_refused++;
                        end
                    end
                end
            end
            default: ;
        endcase

        slot = SLOT_OF_POS[scan_pos];
        if (slot == DASH_SLOT)
            w.segments = SEG_DASH;
        else if (set_mode && int'(slot) + int'(entry_count) < NUM_DIGITS)
            w.segments = SEG_BLANK;
        else if (digits[slot] <= 9)
            w.segments = DIGIT_SEGMENTS[digits[slot]];
        else
            w.segments = SEG_BLANK;
        w.digit_select   = ~(8'b1 << scan_pos);
        w.setting        = set_mode;
        w.digits_entered = set_mode ? entry_count : 3'd0;
        w.entry_rejected = refused;
        expected_words.push_back(w);
    endfunction

    function void check_result(display_word_t got);
        display_word_t exp;
        if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
        end
        exp = expected_words.pop_front();
        checked++;
        if (got.segments !== exp.segments) begin
            $error("segments: expected %h, got %h", exp.segments, got.segments);
            errors++;
        end
        if (got.digit_select !== exp.digit_select) begin
            $error("digit_select: expected %h, got %h", exp.digit_select, got.digit_select);
            errors++;
        end
        if (got.setting !== exp.setting) begin
            $error("setting: expected %b, got %b", exp.setting, got.setting);
            errors++;
        end
        if (got.digits_entered !== exp.digits_entered) begin
            $error("digits_entered: expected %0d, got %0d",
                   exp.digits_entered, got.digits_entered);
            errors++;
        end
        if (got.entry_rejected !== exp.entry_rejected) begin
            $error("entry_rejected: expected %b, got %b",
                   exp.entry_rejected, got.entry_rejected);
            errors++;
        end
    endfunction
endclass

module bcd_clock_with_keypad_set_top_test;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [3:0] KEY_STAR  = 4'd10;
    localparam logic [3:0] KEY_TOP   = 4'd15;
    localparam int RANDOM_WORDS = 900;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_mode;
    logic [3:0] i_key;
    logic       o_valid;
    logic       i_stall;
    logic [6:0] o_segments;
    logic [7:0] o_digit_select;
    logic       o_setting;
    logic [2:0] o_digits_entered;
    logic       o_entry_rejected;

    clock_scoreboard sb;
    bit steady;
    bit hold_req;
    int cycle_count;

    bcd_clock_with_keypad_set_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_key            (i_key),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_segments       (o_segments),
        .o_digit_select   (o_digit_select),
        .o_setting        (o_setting),
        .o_digits_entered (o_digits_entered),
        .o_entry_rejected (o_entry_rejected)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bcd_clock_with_keypad_set_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_input(i_mode, i_key);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_segments, o_digit_select, o_setting,
                              o_digits_entered, o_entry_rejected});
    end

    // result side back-pressure, with an occasional long hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            if (steady)
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(99) < 20);
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic [3:0] key);
        if (!steady && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_key   <= key;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_noise(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 45)
                send_word(MODE_SECOND, 4'($urandom_range(15)));
            else if (r < 75)
                send_word(MODE_SCAN, 4'($urandom_range(15)));
            else
                send_word(2'($urandom_range(3)), 4'($urandom_range(15)));
        end
    endtask

    task automatic enter_time();
        logic [3:0] d [6];
        int hh, mm, ss, r, count;
        r = $urandom_range(99);
        if (r < 30) begin
            case ($urandom_range(2))
                0:       hh = 9;
                1:       hh = 19;
                default: hh = 23;
            endcase
            mm = 59;
            ss = $urandom_range(50, 59);
        end else begin
            hh = $urandom_range(23);
            mm = $urandom_range(59);
            ss = $urandom_range(59);
        end
        d = '{4'(hh / 10), 4'(hh % 10), 4'(mm / 10), 4'(mm % 10), 4'(ss / 10), 4'(ss % 10)};
        // malformed entries: random digits, possibly cut short
        if (r >= 75)
            for (int k = 0; k < 6; k++) d[k] = 4'($urandom_range(9));
        count = (r >= 92) ? $urandom_range(0, 5) : 6;
        send_word(MODE_KEY, KEY_SET);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 25)
                send_noise($urandom_range(1, 3));
            send_word(MODE_KEY, d[k]);
        end
    endtask

    initial begin
        int target;
        bit held_once, held_twice;
        sb = new();
        sb.reset_state();
        steady     = 1'b0;
        hold_req   = 1'b0;
        held_once  = 1'b0;
        held_twice = 1'b0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode  = MODE_SECOND;
        i_key   = 4'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored codes, entry under way, midnight roll-over, refused entry
        send_word(MODE_NONE, KEY_TOP);
        send_word(MODE_KEY, KEY_STAR);
        send_word(MODE_KEY, 4'd12);
        send_word(MODE_KEY, 4'd7);
        send_word(MODE_SECOND, 4'd0);
        send_word(MODE_SCAN, 4'd0);
        send_word(MODE_KEY, KEY_SET);
        send_word(MODE_KEY, KEY_SET);
        send_word(MODE_SECOND, 4'd0);
        send_word(MODE_KEY, 4'd2);
        send_word(MODE_SCAN, 4'd0);
        send_word(MODE_KEY, 4'd3);
        send_word(MODE_KEY, 4'd5);
        send_word(MODE_KEY, 4'd9);
        send_word(MODE_KEY, 4'd5);
        send_word(MODE_KEY, 4'd9);
        send_word(MODE_SECOND, 4'd0);
        send_word(MODE_KEY, KEY_SET);
        send_word(MODE_KEY, 4'd2);
        send_word(MODE_KEY, 4'd4);
        send_word(MODE_KEY, 4'd0);
        send_word(MODE_KEY, 4'd0);
        send_word(MODE_KEY, 4'd0);
        send_word(MODE_KEY, 4'd0);

        target = sb.words + RANDOM_WORDS;
        while (sb.words < target) begin
            steady = (sb.words > target - 600) && (sb.words < target - 450);
            if (!held_once && sb.words > target - 750) begin
                held_once = 1'b1;
                hold_req  = 1'b1;
            end
            if (!held_twice && sb.words > target - 250) begin
                held_twice = 1'b1;
                hold_req   = 1'b1;
            end
            if ($urandom_range(99) < 40)
                enter_time();
            else
                send_noise($urandom_range(1, 30));
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_words.size() != 0) begin
            $error("%0d expected result words never arrived", sb.expected_words.size());
            sb.errors++;
        end

        $display("%0d words in (%0d changing state), %0d results compared, %0d errors",
                 sb.words, sb.active_words, sb.checked, sb.errors);
        $display("%0d times set, %0d entries refused, %0d midnight roll-overs",
                 sb.times_set, sb.entries_refused, sb.midnight_wraps);
        if (sb.errors == 0)
            $display("bcd_clock_with_keypad_set_top test passed");
        else
            $display("bcd_clock_with_keypad_set_top test failed");
        $finish;
    end
endmodule
